// ----- hdl/kmd_pkg.sv -----
package kmd_pkg;

  localparam int NUM_KEYS = 27;

  // event kinds
  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_LONG    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FILTER = 2'd0;
  localparam logic [1:0] CFG_LONG   = 2'd1;
  localparam logic [1:0] CFG_REPEAT = 2'd2;

  localparam logic [7:0]  FILTER_RST = 8'd5;
  localparam logic [15:0] LONG_RST   = 16'd400;
  localparam logic [15:0] REPEAT_RST = 16'd0;
  localparam logic [8:0]  FCOUNT_RST = 9'(FILTER_RST / 2);

  localparam logic [31:0] KEY_PATTERNS [NUM_KEYS] = '{
    32'hefffffff, 32'hfeffffff, 32'hffefffff, 32'hfffeffff, 32'hffffefff,
    32'hfffffeff, 32'hffffffef, 32'hfffffffe, 32'hdfffffff, 32'hfdffffff,
    32'hffdfffff, 32'hfffdffff, 32'hffffdfff, 32'hbfffffff, 32'hffffbfff,
    32'hfffffdff, 32'hfbffffff, 32'hfffffbff, 32'hffffffdf, 32'hffbfffff,
    32'hffffffbf, 32'hfffffffd, 32'hfffbffff, 32'hfffffffb, 32'h7fffffff,
    32'hf7ffffff, 32'hff7fffff
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] key;
    logic       beep;
  } kmd_evt_t;

  typedef struct packed {
    logic [1:0] num;
    kmd_evt_t   first;
    kmd_evt_t   second;
  } kmd_step_t;

  typedef struct packed {
    logic     last;
    kmd_evt_t evt;
  } kmd_out_t;

  // table match, 0 when the word is no single-key pattern
  function automatic logic [4:0] decode_key(input logic [31:0] word);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_PATTERNS[i] == word) k = 5'(i + 1);
    end
    return k;
  endfunction

endpackage

// ----- hdl/key_matrix_debounce_long_press.sv -----
// an accepted item is held in the input register, then its results enter the output queue
// throughput: one item per cycle while each item gives at most one result and the
// sink keeps up; an item with two results can fill the two-entry output queue
// reset: synchronous active-low rst_n clears the input register, output queue and
// debounce state (filter count to 2) and restores the registers to filter 5, long 400, repeat 0
module key_matrix_debounce_long_press (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] scan_word
  input  logic        in_tuser,   // [0] suspend
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] event_kind, [6:2] key_number, [7] beep_start
  output logic        out_tlast
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [4:0] s1_key_r;
  logic       s1_susp_r;
  logic       s1_go;
  logic       in_fire;
  logic       pop;

  kmd_pkg::kmd_step_t step;
  kmd_pkg::kmd_out_t  ent_r   [2];
  kmd_pkg::kmd_out_t  ent_nxt [2];
  logic [1:0]         cnt_r, cnt_nxt, cnt_a;
  logic [2:0]         fill;

  kmd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (s1_valid_r && !s1_susp_r),
    .advance   (s1_go),
    .key       (s1_key_r),
    .step      (step)
  );

  assign pop        = out_tvalid && out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign cnt_a      = pop ? cnt_r - 2'd1 : cnt_r;
  assign fill       = {1'b0, cnt_a} + {1'b0, step.num};
  assign s1_go      = s1_valid_r && (fill <= 3'd2);
  assign in_tready  = !s1_valid_r || s1_go;
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = {ent_r[0].evt.beep, ent_r[0].evt.key, ent_r[0].evt.kind};
  assign out_tlast  = ent_r[0].last;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (s1_go) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key_r  <= kmd_pkg::decode_key(in_tdata);
      s1_susp_r <= in_tuser;
    end
  end

  // output queue: shift out on pop, then append this item's results
  always_comb begin
    ent_nxt[0] = pop ? ent_r[1] : ent_r[0];
    ent_nxt[1] = ent_r[1];
    cnt_nxt    = cnt_a;
    if (s1_go && step.num != 2'd0) begin
      if (cnt_a == 2'd0) begin
        ent_nxt[0] = '{last: step.num == 2'd1, evt: step.first};
        ent_nxt[1] = '{last: 1'b1, evt: step.second};
      end else begin
        ent_nxt[1] = '{last: 1'b1, evt: step.first};
      end
      cnt_nxt = fill[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r[0] <= ent_nxt[0];
    ent_r[1] <= ent_nxt[1];
  end

endmodule

// ----- hdl/kmd_core.sv -----
module kmd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              tick,
  input  logic              advance,
  input  logic [4:0]        key,
  output kmd_pkg::kmd_step_t step
);

  logic [7:0]  filter_ticks_r;
  logic [15:0] long_ticks_r;
  logic [15:0] repeat_ticks_r;

  logic [8:0]  filter_count_r, filter_count_nxt;
  logic        pressed_r, pressed_nxt;
  logic [15:0] hold_count_r, hold_count_nxt;
  logic [15:0] repeat_count_r, repeat_count_nxt;
  logic [4:0]  held_key_r, held_key_nxt;

  logic              has_press;
  logic              has_other;
  kmd_pkg::kmd_evt_t press_evt;
  kmd_pkg::kmd_evt_t other_evt;
  logic [15:0]       hold_inc;
  logic [15:0]       repeat_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_ticks_r <= kmd_pkg::FILTER_RST;
      long_ticks_r   <= kmd_pkg::LONG_RST;
      repeat_ticks_r <= kmd_pkg::REPEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kmd_pkg::CFG_FILTER: filter_ticks_r <= cfg_data[7:0];
        kmd_pkg::CFG_LONG:   long_ticks_r   <= cfg_data;
        kmd_pkg::CFG_REPEAT: repeat_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    filter_count_nxt = filter_count_r;
    pressed_nxt      = pressed_r;
    hold_count_nxt   = hold_count_r;
    repeat_count_nxt = repeat_count_r;
    held_key_nxt     = held_key_r;
    has_press        = 1'b0;
    has_other        = 1'b0;
    press_evt        = '{kind: kmd_pkg::KIND_PRESS, key: key, beep: 1'b1};
    other_evt        = '{kind: kmd_pkg::KIND_LONG, key: key, beep: 1'b0};
    hold_inc         = hold_count_r + 16'd1;
    repeat_inc       = repeat_count_r + 16'd1;

    if (key != 5'd0) begin
      if (filter_count_r < {1'b0, filter_ticks_r}) begin
        filter_count_nxt = {1'b0, filter_ticks_r};
      end else if (filter_count_r < {filter_ticks_r, 1'b0}) begin
        filter_count_nxt = filter_count_r + 9'd1;
      end else begin
        if (!pressed_r) begin
          pressed_nxt  = 1'b1;
          held_key_nxt = key;
          has_press    = 1'b1;
        end
        if (long_ticks_r != 16'd0) begin
          if (hold_count_r < long_ticks_r) begin
            hold_count_nxt = hold_inc;
            if (hold_inc == long_ticks_r) has_other = 1'b1;
          end else if (repeat_ticks_r != 16'd0) begin
            repeat_count_nxt = repeat_inc;
            if (repeat_inc >= repeat_ticks_r) begin
              repeat_count_nxt = 16'd0;
              has_other        = 1'b1;
              other_evt.kind   = kmd_pkg::KIND_PRESS;
            end
          end
        end
      end
    end else begin
      if (filter_count_r > {1'b0, filter_ticks_r}) begin
        filter_count_nxt = {1'b0, filter_ticks_r};
      end else if (filter_count_r != 9'd0) begin
        filter_count_nxt = filter_count_r - 9'd1;
      end else if (pressed_r) begin
        pressed_nxt = 1'b0;
        has_other   = 1'b1;
        other_evt   = '{kind: kmd_pkg::KIND_RELEASE, key: held_key_r, beep: 1'b0};
      end
      hold_count_nxt   = 16'd0;
      repeat_count_nxt = 16'd0;
    end

    // press always comes first when both occur
    step.first  = has_press ? press_evt : other_evt;
    step.second = other_evt;
    step.num    = tick ? ({1'b0, has_press} + {1'b0, has_other}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_count_r <= kmd_pkg::FCOUNT_RST;
      pressed_r      <= 1'b0;
      hold_count_r   <= 16'd0;
      repeat_count_r <= 16'd0;
      held_key_r     <= 5'd0;
    end else if (tick && advance) begin
      filter_count_r <= filter_count_nxt;
      pressed_r      <= pressed_nxt;
      hold_count_r   <= hold_count_nxt;
      repeat_count_r <= repeat_count_nxt;
      held_key_r     <= held_key_nxt;
    end
  end

endmodule

// ----- hdl/kmd_checker.sv -----
module kmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:2] != 5'd0 && out_tdata[6:2] <= 5'd27
                   && out_tdata[1:0] != 2'd3)
    else $error("bad key number or event kind");

  a_beep_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[1:0] == kmd_pkg::KIND_PRESS)
    else $error("beep on a non-press event");

endmodule

bind key_matrix_debounce_long_press kmd_checker u_kmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- sim/key_matrix_debounce_long_press_test.sv -----
module key_matrix_debounce_long_press_test;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES = 12;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] key_no;
    logic       beep;
    logic       last;
  } key_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = kmd_pkg::CFG_FILTER;
  logic [15:0] cfg_data = 16'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'hffff_ffff;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  // shadow of the registers and the debounce state
  logic [7:0]  f_ticks;
  logic [15:0] l_ticks;
  logic [15:0] r_ticks;
  logic [8:0]  fcnt;
  logic        pressed;
  logic [15:0] hold_cnt;
  logic [15:0] rep_cnt;
  logic [4:0]  held_key;

  key_event_t events_due[$];
  key_event_t seen_ev;
  key_event_t want_ev;

  int errors = 0;
  int scans_sent = 0;
  int suspends = 0;
  int presses = 0;
  int releases = 0;
  int longs = 0;
  int quiet = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  key_matrix_debounce_long_press uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      seen_ev = '{kind: out_tdata[1:0], key_no: out_tdata[6:2], beep: out_tdata[7],
                  last: out_tlast};
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, actual %p", $time, seen_ev);
      end else begin
        want_ev = events_due.pop_front();
        if (seen_ev.kind !== want_ev.kind || seen_ev.key_no !== want_ev.key_no ||
            seen_ev.beep !== want_ev.beep || seen_ev.last !== want_ev.last) begin
          errors++;
          $display("%0t: event mismatch, expected %p, actual %p", $time, want_ev, seen_ev);
        end
      end
      case (seen_ev.kind)
        kmd_pkg::KIND_PRESS: presses++;
        kmd_pkg::KIND_RELEASE: releases++;
        default: longs++;
      endcase
    end
  end

  // one scan tick through the debounce, long press and repeat logic
  task automatic debounce_tick(input logic [31:0] word, input logic susp);
    key_event_t tick_ev[2];
    logic [4:0] code;
    int n;
    n = 0;
    code = 5'd0;
    if (susp) return;
    for (int i = 0; i < kmd_pkg::NUM_KEYS; i++) begin
      if (word == kmd_pkg::KEY_PATTERNS[i]) code = 5'(i + 1);
    end
    if (code != 5'd0) begin
      if (fcnt < f_ticks) begin
        fcnt = 9'(f_ticks);
      end else if (fcnt < 2 * f_ticks) begin
        fcnt = fcnt + 9'd1;
      end else begin
        if (!pressed) begin
          pressed = 1'b1;
          held_key = code;
          tick_ev[n] = '{kind: kmd_pkg::KIND_PRESS, key_no: code, beep: 1'b1, last: 1'b0};
          n++;
        end
        if (l_ticks != 16'd0) begin
          if (hold_cnt < l_ticks) begin
            hold_cnt = hold_cnt + 16'd1;
            if (hold_cnt == l_ticks) begin
              tick_ev[n] = '{kind: kmd_pkg::KIND_LONG, key_no: code, beep: 1'b0,
                             last: 1'b0};
              n++;
            end
          end else if (r_ticks != 16'd0) begin
            rep_cnt = rep_cnt + 16'd1;
            if (rep_cnt >= r_ticks) begin
              rep_cnt = 16'd0;
              tick_ev[n] = '{kind: kmd_pkg::KIND_PRESS, key_no: code, beep: 1'b0,
                             last: 1'b0};
              n++;
            end
          end
        end
      end
    end else begin
      if (fcnt > f_ticks) begin
        fcnt = 9'(f_ticks);
      end else if (fcnt != 9'd0) begin
        fcnt = fcnt - 9'd1;
      end else if (pressed) begin
        pressed = 1'b0;
        tick_ev[n] = '{kind: kmd_pkg::KIND_RELEASE, key_no: held_key, beep: 1'b0,
                       last: 1'b0};
        n++;
      end
      hold_cnt = 16'd0;
      rep_cnt = 16'd0;
    end
    if (n > 0) tick_ev[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) events_due.push_back(tick_ev[i]);
  endtask

  task automatic send_scan(input logic [31:0] word, input logic susp);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    in_tuser <= susp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    debounce_tick(word, susp);
    if (susp) suspends++;
    else scans_sent++;
  endtask

  // wait for every pending event, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] f, input logic [15:0] l,
                              input logic [15:0] r);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNUSED;
    cfg_data <= 16'($urandom());
    @(posedge clk);
    cfg_index <= kmd_pkg::CFG_FILTER;
    cfg_data <= {8'($urandom()), f};
    @(posedge clk);
    f_ticks = f;
    cfg_index <= kmd_pkg::CFG_LONG;
    cfg_data <= l;
    @(posedge clk);
    l_ticks = l;
    cfg_index <= kmd_pkg::CFG_REPEAT;
    cfg_data <= r;
    @(posedge clk);
    r_ticks = r;
    cfg_we <= 1'b0;
  endtask

  // a word that decodes to no key
  function automatic logic [31:0] empty_scan();
    case ($urandom_range(5))
      0, 1, 2: return 32'hffff_ffff;
      3: return $urandom();
      // single zero on a row bit the table never uses
      4: return ~(32'h1 << (4 * $urandom_range(4) + 3));
      default: return 32'h0000_0000;
    endcase
  endfunction

  task automatic test_reset_values();
    send_scan(32'h0000_0000, 1'b0);
    send_scan(32'hffff_fff7, 1'b0);
    repeat (7) send_scan(kmd_pkg::KEY_PATTERNS[kmd_pkg::NUM_KEYS-1], 1'b0);
    send_scan(kmd_pkg::KEY_PATTERNS[0], 1'b1);
    repeat (7) send_scan(32'hffff_ffff, 1'b0);
    settle();
  endtask

  task automatic test_press_and_long_same_tick();
    program_regs(8'd1, 16'd1, 16'd1);
    repeat (4) send_scan(kmd_pkg::KEY_PATTERNS[0], 1'b0);
    // another key while held: repeat follows it, release keeps the first
    send_scan(kmd_pkg::KEY_PATTERNS[7], 1'b0);
    repeat (3) send_scan(32'hffff_ffff, 1'b0);
    settle();
  endtask

  task automatic test_zero_filter();
    program_regs(8'd0, 16'd2, 16'd3);
    repeat (3) send_scan(kmd_pkg::KEY_PATTERNS[13], 1'b0);
    send_scan(32'hffff_ffff, 1'b0);
    settle();
  endtask

  task automatic random_holds(input int budget);
    int stop_at;
    int span;
    int hold_len;
    int gap_len;
    int code;
    int pick;
    int noise_pct;
    stop_at = scans_sent + budget;
    while (scans_sent < stop_at) begin
      code = $urandom_range(kmd_pkg::NUM_KEYS - 1);
      // a long filter only debounces on a clean run
      noise_pct = (f_ticks > 32) ? 0 : 4;
      span = 2 * f_ticks + l_ticks + 3 * r_ticks + 6;
      if (span > 400) span = 400;
      if (f_ticks > 32) hold_len = 2 * f_ticks + $urandom_range(60);
      else hold_len = $urandom_range(span, 1);
      for (int i = 0; i < hold_len && scans_sent < stop_at; i++) begin
        pick = $urandom_range(99);
        if (pick < noise_pct) send_scan(empty_scan(), 1'b0);
        else if (pick < noise_pct + 4) send_scan($urandom(), 1'b1);
        else if (pick < noise_pct + 6)
          send_scan(kmd_pkg::KEY_PATTERNS[$urandom_range(kmd_pkg::NUM_KEYS-1)], 1'b0);
        else send_scan(kmd_pkg::KEY_PATTERNS[code], 1'b0);
      end
      if ($urandom_range(3) == 0) gap_len = $urandom_range(f_ticks + 1, 1);
      else gap_len = f_ticks + 2 + $urandom_range(2);
      for (int i = 0; i < gap_len && scans_sent < stop_at; i++) begin
        send_scan(empty_scan(), $urandom_range(19) == 0);
      end
      if ($urandom_range(24) == 0) settle();
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == PHASES / 3) begin
        src_idle_pct = 85;
        sink_idle_pct = 18;
      end else if (p == 2 * PHASES / 3) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      case (p % 6)
        0: program_regs(8'($urandom_range(6, 1)), 16'($urandom_range(20)),
                        16'($urandom_range(5)));
        1: program_regs(8'd1, 16'd1, 16'd1);
        2: program_regs(8'($urandom_range(4, 1)), 16'($urandom_range(8, 2)), 16'd0);
        3: program_regs(8'($urandom_range(4, 1)), 16'd0, 16'($urandom_range(3, 1)));
        4: program_regs(8'd255, 16'hffff, 16'hffff);
        default: program_regs(8'd0, 16'($urandom_range(6, 1)), 16'($urandom_range(3, 1)));
      endcase
      random_holds((f_ticks > 32) ? 320 : 120);
    end
  endtask

  initial begin
    f_ticks = kmd_pkg::FILTER_RST;
    l_ticks = kmd_pkg::LONG_RST;
    r_ticks = kmd_pkg::REPEAT_RST;
    fcnt = 9'(f_ticks / 2);
    pressed = 1'b0;
    hold_cnt = 16'd0;
    rep_cnt = 16'd0;
    held_key = 5'd0;
    src_idle_pct = 18;
    sink_idle_pct = 85;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_press_and_long_same_tick();
    test_zero_filter();
    test_random_traffic();

    settle();
    errors += events_due.size();
    $display("ran %0d scan items plus %0d suspended ones over %0d register settings",
             scans_sent, suspends, PHASES + 2);
    $display("checked %0d press or repeat, %0d long press and %0d release events",
             presses, longs, releases);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
